// ----- design/rfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reply frame receiver package
// Shared widths, request and status codes, register indexes, reset values.
// ----------------------------------------------------------------------------
package rfr_pkg;

    localparam int REQ_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 3;
    localparam int PAYLOAD_W = 48;
    localparam int TICK_W    = 24;
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 4;

    // Request codes carried in req_type.
    localparam logic [REQ_W-1:0] REQ_ARM  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BYTE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd2;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_REPLY_LENGTH   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd2;
    localparam logic [1:0] REG_GRACE_TICKS    = 2'd3;

    localparam logic [BYTE_W-1:0] RST_DEVICE_ADDRESS = 8'hE0;
    localparam logic [LEN_W-1:0]  RST_REPLY_LENGTH   = 3'd1;
    localparam logic [TICK_W-1:0] RST_TIMEOUT_TICKS  = 24'd1000;
    localparam logic [TICK_W-1:0] RST_GRACE_TICKS    = 24'd50;

    // Largest data count the payload field can carry.
    localparam int PAYLOAD_BYTES = PAYLOAD_W / BYTE_W;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_HUNT    = 3'b010,
        PH_COLLECT = 3'b100
    } phase_t;

endpackage

// ----- design/rfr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reply frame receiver channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface rfr_req_if;
    logic                        valid;
    logic                        ready;
    logic [rfr_pkg::REQ_W-1:0]   req_type;
    logic [rfr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface rfr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rfr_pkg::STATUS_W-1:0]  status;
    logic [rfr_pkg::PAYLOAD_W-1:0] payload;
    logic [rfr_pkg::LEN_W-1:0]     payload_len;

    modport source (output valid, output status, output payload, output payload_len,
                    input ready);
    modport sink   (input valid, input status, input payload, input payload_len,
                    output ready);
endinterface

// ----- design/reply_frame_receiver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reply frame receiver
// Hunts for the device address, collects data bytes with an additive
// checksum and reports ok, mismatch or timeout under a tick deadline.
// ----------------------------------------------------------------------------
//  Channel    Dir  Handshake            Payload
//  item_in    in   valid/ready          req_type, rx_byte
//  item_out   out  valid/ready          status, payload, payload_len
//  APB        in   psel/penable/pready  paddr, pwdata, prdata
//
//  An item is registered at acceptance and processed from that register, so
//  one item per cycle is taken unless stalled, and each result is registered.
//  The only stall is a full result register with item_out.ready low, and only
//  an item that produces a result waits on it. rst_n clears the frame state
//  to idle and the registers to their defaults at once.
// ----------------------------------------------------------------------------
module reply_frame_receiver_unit #(
    parameter int MAX_FRAME_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rfr_req_if.sink                       item_in,
    rfr_rsp_if.source                     item_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rfr_pkg::CFG_AW-1:0]    paddr,
    input  logic [rfr_pkg::CFG_DW-1:0]    pwdata,
    output logic [rfr_pkg::CFG_DW-1:0]    prdata,
    output logic                          pready
);
    import rfr_pkg::*;

    // Data bytes per frame are capped by the frame size and by the payload.
    localparam int MAX_DATA_INT = (MAX_FRAME_BYTES - 2 < PAYLOAD_BYTES) ?
                                  (MAX_FRAME_BYTES - 2) : PAYLOAD_BYTES;
    localparam logic [LEN_W-1:0] MAX_DATA = LEN_W'(MAX_DATA_INT);

    // Configuration registers.
    logic [BYTE_W-1:0] device_address_reg;
    logic [LEN_W-1:0]  reply_length_reg;
    logic [TICK_W-1:0] timeout_ticks_reg;
    logic [TICK_W-1:0] grace_ticks_reg;
    logic              cfg_write;

    // Input register.
    logic              in_valid_reg;
    logic [REQ_W-1:0]  req_type_reg;
    logic [BYTE_W-1:0] rx_byte_reg;

    // Frame state.
    phase_t               phase_reg, phase_next;
    logic [LEN_W-1:0]     bytes_seen_reg, bytes_seen_next;
    logic [BYTE_W-1:0]    running_sum_reg, running_sum_next;
    logic [PAYLOAD_W-1:0] data_shift_reg, data_shift_next;
    logic [TICK_W-1:0]    ticks_left_reg, ticks_left_next;

    // Result register.
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [LEN_W-1:0]     payload_len_reg, payload_len_next;

    logic             has_result;
    logic             advance;
    logic [LEN_W-1:0] eff_length;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= RST_DEVICE_ADDRESS;
            reply_length_reg   <= RST_REPLY_LENGTH;
            timeout_ticks_reg  <= RST_TIMEOUT_TICKS;
            grace_ticks_reg    <= RST_GRACE_TICKS;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_DEVICE_ADDRESS: device_address_reg <= pwdata[BYTE_W-1:0];
                REG_REPLY_LENGTH:   reply_length_reg   <= pwdata[LEN_W-1:0];
                REG_TIMEOUT_TICKS:  timeout_ticks_reg  <= pwdata[TICK_W-1:0];
                REG_GRACE_TICKS:    grace_ticks_reg    <= pwdata[TICK_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DEVICE_ADDRESS: prdata = {{(CFG_DW-BYTE_W){1'b0}}, device_address_reg};
            REG_REPLY_LENGTH:   prdata = {{(CFG_DW-LEN_W){1'b0}}, reply_length_reg};
            REG_TIMEOUT_TICKS:  prdata = {{(CFG_DW-TICK_W){1'b0}}, timeout_ticks_reg};
            REG_GRACE_TICKS:    prdata = {{(CFG_DW-TICK_W){1'b0}}, grace_ticks_reg};
            default:            prdata = '0;
        endcase
    end

    assign eff_length = (reply_length_reg < MAX_DATA) ? reply_length_reg : MAX_DATA;

    // ---------------- input register ----------------
    // An item without a result never waits on the result register.
    assign advance       = in_valid_reg && (!has_result || !out_valid_reg || item_out.ready);
    assign item_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            req_type_reg <= item_in.req_type;
            rx_byte_reg  <= item_in.rx_byte;
        end
    end

    // ---------------- frame logic ----------------
    always_comb
    begin
        phase_next       = phase_reg;
        bytes_seen_next  = bytes_seen_reg;
        running_sum_next = running_sum_reg;
        data_shift_next  = data_shift_reg;
        ticks_left_next  = ticks_left_reg;
        has_result       = 1'b0;
        status_next      = ST_OK;
        payload_next     = '0;
        payload_len_next = '0;

        if (req_type_reg == REQ_ARM)
        begin
            phase_next       = PH_HUNT;
            bytes_seen_next  = '0;
            running_sum_next = '0;
            data_shift_next  = '0;
            ticks_left_next  = timeout_ticks_reg;
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (req_type_reg == REQ_TICK)
            begin
                // A tick that finds one or zero ticks left ends the wait.
                if (ticks_left_reg[TICK_W-1:1] == '0)
                begin
                    ticks_left_next = '0;
                    phase_next      = PH_IDLE;
                    has_result      = 1'b1;
                    status_next     = ST_TIMEOUT;
                end
                else
                begin
                    ticks_left_next = ticks_left_reg - 1'b1;
                end
            end
            else if (req_type_reg == REQ_BYTE)
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte_reg == device_address_reg)
                        begin
                            phase_next       = PH_COLLECT;
                            bytes_seen_next  = '0;
                            data_shift_next  = '0;
                            running_sum_next = rx_byte_reg;
                            if (ticks_left_reg < grace_ticks_reg)
                            begin
                                ticks_left_next = grace_ticks_reg;
                            end
                        end
                    end
                    PH_COLLECT:
                    begin
                        if (bytes_seen_reg < eff_length)
                        begin
                            data_shift_next  = {data_shift_reg[PAYLOAD_W-BYTE_W-1:0],
                                                rx_byte_reg};
                            running_sum_next = running_sum_reg + rx_byte_reg;
                            bytes_seen_next  = bytes_seen_reg + 1'b1;
                        end
                        else
                        begin
                            // This byte is the checksum.
                            phase_next = PH_IDLE;
                            has_result = 1'b1;
                            if (rx_byte_reg == running_sum_reg)
                            begin
                                status_next      = ST_OK;
                                payload_next     = data_shift_reg;
                                payload_len_next = bytes_seen_reg;
                            end
                            else
                            begin
                                status_next = ST_MISMATCH;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bytes_seen_reg  <= '0;
            running_sum_reg <= '0;
            data_shift_reg  <= '0;
            ticks_left_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            bytes_seen_reg  <= bytes_seen_next;
            running_sum_reg <= running_sum_next;
            data_shift_reg  <= data_shift_next;
            ticks_left_reg  <= ticks_left_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (item_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            status_reg      <= status_next;
            payload_reg     <= payload_next;
            payload_len_reg <= payload_len_next;
        end
    end

    assign item_out.valid       = out_valid_reg;
    assign item_out.status      = status_reg;
    assign item_out.payload     = payload_reg;
    assign item_out.payload_len = payload_len_reg;

    // ---------------- assertions ----------------
    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_result |=> phase_reg == PH_IDLE)
        else $error("frame state not idle after a result");

    a_failed_result_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> payload_reg == '0 && payload_len_reg == '0)
        else $error("failed result carries payload");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_seen_reg <= MAX_DATA)
        else $error("data count beyond the frame limit");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(req_type_reg)
                                     && $stable(rx_byte_reg))
        else $error("stalled item was lost");

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> payload_len_reg <= MAX_DATA)
        else $error("result length beyond the frame limit");

endmodule
